[design/brs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, codes and defaults of the bilinear RGBA scaler.
// ----------------------------------------------------------------------------
package brs_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_LINES     = 3;
   localparam int DEF_FRAC_BITS = 16;

   localparam int DIM_W       = 11;
   localparam int POS_W       = 26;
   localparam int PIX_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 26;
   localparam int ADDR_MAX_W  = 14;
   localparam int FRAC_MAX_W  = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_FILL = 3'd6;

   localparam logic [7:0] BYTE_MAX = 8'hFF;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_PIXEL  = 2'd0,
      ST_PUSHED = 2'd1,
      ST_WAIT   = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_STATUS = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_COPY   = 2'd2,
      CMD_BLEND  = 2'd3
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_READ  = 2'd1,
      BK_BLEND = 2'd2
   } back_state_type;

   typedef struct packed {
      cmd_kind_type                    kind;
      status_type                      status;
      logic [PIX_W-1:0]                data;
      logic [3:0][ADDR_MAX_W-1:0]      addr;
      logic [FRAC_MAX_W-1:0]           fx;
      logic [FRAC_MAX_W-1:0]           fy;
      logic                            row_end;
      logic                            frame_end;
   } cmd_type;

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] step);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + {1'b0, step};
      return sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
   endfunction

endpackage
`default_nettype wire

[design/brs_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module brs_fifo
   import brs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      din,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      dout,
   output logic         empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[design/brs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_front
// Configuration registers, frame counters and transaction classification.
// ----------------------------------------------------------------------------
module brs_front
   import brs_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int LINES     = DEF_LINES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_push,
   input  wire logic                  req_opcode,
   input  wire logic [PIX_W-1:0]      req_src_pixel,
   output logic                       req_full,
   input  wire logic                  cmd_full,
   output logic                       cmd_push,
   output cmd_type                    cmd
);

   localparam int               RECIP_SH = 16;
   localparam logic [16:0]      RECIP    = 17'(((1 << RECIP_SH) + LINES - 1) / LINES);
   localparam logic [12:0]      MAXW_X   = 13'(MAX_WIDTH);

   logic [DIM_W-1:0]  src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [POS_W-1:0]  x_step_ff, y_step_ff;
   logic              alpha_fill_ff;

   logic [DIM_W-1:0]  push_column_ff, push_column_in;
   logic [DIM_W-1:0]  push_row_ff, push_row_in;
   logic [DIM_W-1:0]  out_column_ff, out_column_in;
   logic [DIM_W-1:0]  out_row_ff, out_row_in;
   logic [POS_W-1:0]  x_position_ff, x_position_in;
   logic [POS_W-1:0]  y_position_ff, y_position_in;

   logic              accept, scaling, both_done, src_done, out_done;
   logic [DIM_W-1:0]  w, h, ow, oh, wm1, hm1;
   logic [DIM_W-1:0]  pr, pc, orow, ocol, top, top_ls, y1, x0, x1;
   logic [POS_W-1:0]  xp, yp, yint, xint;
   logic [1:0]        y0_line, y1_line;
   logic              push_block, pass_ready, emit;
   logic [PIX_W-1:0]  pix;

   function automatic logic [1:0] line_of(input logic [DIM_W-1:0] v);
      logic [DIM_W+16:0] prod;
      logic [DIM_W-1:0]  q;
      logic [DIM_W+1:0]  r;
      prod = (DIM_W+17)'(v) * (DIM_W+17)'(RECIP);
      q    = DIM_W'(prod >> RECIP_SH);
      r    = (DIM_W+2)'(v) - (DIM_W+2)'(q) * (DIM_W+2)'(LINES);
      return r[1:0];
   endfunction

   function automatic logic [ADDR_MAX_W-1:0] addr_of(input logic [1:0] line,
                                                     input logic [DIM_W-1:0] col);
      return ADDR_MAX_W'(line) * ADDR_MAX_W'(MAX_WIDTH) + ADDR_MAX_W'(col);
   endfunction

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_W'(1024);
         src_height_ff <= DIM_W'(1024);
         dst_width_ff  <= '0;
         dst_height_ff <= '0;
         x_step_ff     <= '0;
         y_step_ff     <= '0;
         alpha_fill_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[DIM_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data[DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_data[DIM_W-1:0];
            CSR_X_STEP:     x_step_ff     <= csr_data[POS_W-1:0];
            CSR_Y_STEP:     y_step_ff     <= csr_data[POS_W-1:0];
            CSR_ALPHA_FILL: alpha_fill_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      scaling = (dst_width_ff != '0) && (dst_height_ff != '0);
      if (src_width_ff == '0) begin
         w = DIM_W'(1);
      end else if ({2'b00, src_width_ff} > MAXW_X) begin
         w = DIM_W'(MAX_WIDTH);
      end else begin
         w = src_width_ff;
      end
      h   = (src_height_ff == '0) ? DIM_W'(1) : src_height_ff;
      ow  = scaling ? dst_width_ff : w;
      oh  = scaling ? dst_height_ff : h;
      wm1 = w - 1'b1;
      hm1 = h - 1'b1;

      both_done = (push_row_ff >= h) && (out_row_ff >= oh);
      pr   = both_done ? '0 : push_row_ff;
      pc   = both_done ? '0 : push_column_ff;
      orow = both_done ? '0 : out_row_ff;
      ocol = both_done ? '0 : out_column_ff;
      xp   = both_done ? '0 : x_position_ff;
      yp   = both_done ? '0 : y_position_ff;
      src_done = (pr >= h);
      out_done = (orow >= oh);

      yint   = yp >> FRAC_BITS;
      xint   = xp >> FRAC_BITS;
      top    = (yint < POS_W'(hm1)) ? DIM_W'(yint) : hm1;
      top_ls = scaling ? top : orow;
      y1     = ({1'b0, top} + 1'b1 < {1'b0, h}) ? top + 1'b1 : hm1;
      x0     = (xint < POS_W'(wm1)) ? DIM_W'(xint) : wm1;
      x1     = ({1'b0, x0} + 1'b1 < {1'b0, w}) ? x0 + 1'b1 : wm1;

      y0_line = line_of(top);
      if (y1 == top) begin
         y1_line = y0_line;
      end else begin
         y1_line = (y0_line == 2'(LINES - 1)) ? 2'd0 : y0_line + 1'b1;
      end

      push_block = !out_done &&
                   ({1'b0, pr} >= {1'b0, top_ls} + (DIM_W+1)'(LINES));
      pass_ready = (pr > orow) || ((pr == orow) && (pc > ocol));
      pix = alpha_fill_ff ? {BYTE_MAX, req_src_pixel[23:0]} : req_src_pixel;
   end

   always_comb begin
      cmd            = '0;
      cmd.kind       = CMD_STATUS;
      cmd.status     = ST_DONE;
      emit           = 1'b0;
      push_row_in    = pr;
      push_column_in = pc;
      out_row_in     = orow;
      out_column_in  = ocol;
      x_position_in  = xp;
      y_position_in  = yp;

      if (req_opcode == OP_PUSH) begin
         if (src_done) begin
            cmd.status = ST_DONE;
         end else if (push_block) begin
            cmd.status = ST_WAIT;
         end else begin
            cmd.kind    = CMD_WRITE;
            cmd.status  = ST_PUSHED;
            cmd.data    = pix;
            cmd.addr[0] = addr_of(line_of(pr), pc);
            if (pc + 1'b1 >= w) begin
               push_column_in = '0;
               push_row_in    = pr + 1'b1;
            end else begin
               push_column_in = pc + 1'b1;
            end
         end
      end else if (out_done) begin
         cmd.status = ST_DONE;
      end else if (scaling) begin
         if (pr <= y1) begin
            cmd.status = ST_WAIT;
         end else begin
            cmd.kind      = CMD_BLEND;
            cmd.status    = ST_PIXEL;
            cmd.addr[0]   = addr_of(y0_line, x0);
            cmd.addr[1]   = addr_of(y0_line, x1);
            cmd.addr[2]   = addr_of(y1_line, x0);
            cmd.addr[3]   = addr_of(y1_line, x1);
            cmd.fx        = FRAC_MAX_W'(xp[FRAC_BITS-1:0]);
            cmd.fy        = FRAC_MAX_W'(yp[FRAC_BITS-1:0]);
            x_position_in = sat_add(xp, x_step_ff);
            emit          = 1'b1;
         end
      end else begin
         if (!pass_ready) begin
            cmd.status = ST_WAIT;
         end else begin
            cmd.kind    = CMD_COPY;
            cmd.status  = ST_PIXEL;
            cmd.addr[0] = addr_of(line_of(orow), ocol);
            emit        = 1'b1;
         end
      end

      if (emit) begin
         if (ocol + 1'b1 >= ow) begin
            out_column_in = '0;
            out_row_in    = orow + 1'b1;
            if (scaling) begin
               x_position_in = '0;
               y_position_in = sat_add(yp, y_step_ff);
            end
            cmd.row_end   = 1'b1;
            cmd.frame_end = (orow + 1'b1 >= oh);
         end else begin
            out_column_in = ocol + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         push_column_ff <= '0;
         push_row_ff    <= '0;
         out_column_ff  <= '0;
         out_row_ff     <= '0;
         x_position_ff  <= '0;
         y_position_ff  <= '0;
      end else if (accept) begin
         push_column_ff <= push_column_in;
         push_row_ff    <= push_row_in;
         out_column_ff  <= out_column_in;
         out_row_ff     <= out_row_in;
         x_position_ff  <= x_position_in;
         y_position_ff  <= y_position_in;
      end
   end

endmodule
`default_nettype wire

[design/brs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_back
// Line store, neighbour fetch, shared blend unit and result register.
// ----------------------------------------------------------------------------
module brs_back
   import brs_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int LINES     = DEF_LINES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_empty,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   input  wire logic          rsp_pop,
   output logic               rsp_empty,
   output logic [1:0]         rsp_status,
   output logic [PIX_W-1:0]   rsp_out_pixel,
   output logic               rsp_row_end,
   output logic               rsp_frame_end
);

   localparam int DEPTH  = LINES * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int F      = FRAC_BITS;

   logic [PIX_W-1:0]    mem [DEPTH];
   logic [PIX_W-1:0]    rdata_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                mem_we;

   back_state_type      state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [1:0]          ch_ff, ch_in;
   logic [1:0]          ph_ff, ph_in;
   logic [3:0][PIX_W-1:0] nb_ff, nb_in;
   logic [F+7:0]        h0_ff, h0_in, h1_ff, h1_in;
   logic [3:0][7:0]     res_ff, res_in;

   logic                out_valid_ff, out_valid_in;
   status_type          out_status_ff, out_status_in;
   logic [PIX_W-1:0]    out_pixel_ff, out_pixel_in;
   logic                out_row_end_ff, out_row_end_in;
   logic                out_frame_end_ff, out_frame_end_in;

   logic                start;
   logic [7:0]          pa, pb;
   logic signed [8:0]   dab;
   logic signed [F+1:0] fxs;
   logic signed [F+9:0] prod_h, sum_h;
   logic signed [F+8:0] dh;
   logic signed [F:0]   fys;
   logic signed [2*F+9:0] prod_v, sum_v;
   logic [7:0]          vbyte;
   logic [1:0]          nb_sel;

   assign start     = (state_ff == BK_IDLE) && !cmd_empty && (!out_valid_ff || rsp_pop);
   assign cmd_pop   = start;
   assign mem_we    = start && (cmd.kind == CMD_WRITE);
   assign rd_addr   = cur_ff.addr[cnt_ff[1:0]][ADDR_W-1:0];
   assign nb_sel    = 2'(cnt_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.addr[0][ADDR_W-1:0]] <= cmd.data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start && (cmd.kind == CMD_COPY || cmd.kind == CMD_BLEND)) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (cur_ff.kind == CMD_COPY && cnt_ff == 3'd1) begin
               state_in = BK_IDLE;
            end else if (cnt_ff == 3'd4) begin
               state_in = BK_BLEND;
            end
         end
         BK_BLEND: begin
            if (ch_ff == 2'd3 && ph_ff == 2'd2) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pa     = (ph_ff == 2'd0) ? nb_ff[0][{ch_ff, 3'b000} +: 8] : nb_ff[2][{ch_ff, 3'b000} +: 8];
      pb     = (ph_ff == 2'd0) ? nb_ff[1][{ch_ff, 3'b000} +: 8] : nb_ff[3][{ch_ff, 3'b000} +: 8];
      dab    = $signed({1'b0, pb}) - $signed({1'b0, pa});
      fxs    = $signed({1'b0, cur_ff.fx[F-1:0]});
      prod_h = (F+10)'(dab) * (F+10)'(fxs);
      sum_h  = $signed((F+10)'({pa, {F{1'b0}}})) + prod_h;
      dh     = $signed({1'b0, h1_ff}) - $signed({1'b0, h0_ff});
      fys    = $signed({1'b0, cur_ff.fy[F-1:0]});
      prod_v = (2*F+10)'(dh) * (2*F+10)'(fys);
      sum_v  = $signed((2*F+10)'({h0_ff, {F{1'b0}}})) + prod_v;
      vbyte  = sum_v[2*F+7:2*F];
   end

   always_comb begin
      cur_in           = cur_ff;
      cnt_in           = cnt_ff;
      ch_in            = ch_ff;
      ph_in            = ph_ff;
      nb_in            = nb_ff;
      h0_in            = h0_ff;
      h1_in            = h1_ff;
      res_in           = res_ff;
      out_valid_in     = out_valid_ff && !rsp_pop;
      out_status_in    = out_status_ff;
      out_pixel_in     = out_pixel_ff;
      out_row_end_in   = out_row_end_ff;
      out_frame_end_in = out_frame_end_ff;

      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               cur_in = cmd;
               cnt_in = '0;
               ch_in  = '0;
               ph_in  = '0;
               if (cmd.kind == CMD_STATUS || cmd.kind == CMD_WRITE) begin
                  out_valid_in     = 1'b1;
                  out_status_in    = cmd.status;
                  out_pixel_in     = '0;
                  out_row_end_in   = 1'b0;
                  out_frame_end_in = 1'b0;
               end
            end
         end
         BK_READ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               nb_in[nb_sel] = rdata_ff;
            end
            if (cur_ff.kind == CMD_COPY && cnt_ff == 3'd1) begin
               out_valid_in     = 1'b1;
               out_status_in    = cur_ff.status;
               out_pixel_in     = rdata_ff;
               out_row_end_in   = cur_ff.row_end;
               out_frame_end_in = cur_ff.frame_end;
            end
         end
         BK_BLEND: begin
            case (ph_ff)
               2'd0: begin
                  h0_in = sum_h[F+7:0];
                  ph_in = 2'd1;
               end
               2'd1: begin
                  h1_in = sum_h[F+7:0];
                  ph_in = 2'd2;
               end
               default: begin
                  res_in[ch_ff] = vbyte;
                  ph_in         = 2'd0;
                  ch_in         = ch_ff + 1'b1;
                  if (ch_ff == 2'd3) begin
                     out_valid_in     = 1'b1;
                     out_status_in    = cur_ff.status;
                     out_pixel_in     = {vbyte, res_ff[2], res_ff[1], res_ff[0]};
                     out_row_end_in   = cur_ff.row_end;
                     out_frame_end_in = cur_ff.frame_end;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff           <= cur_in;
      cnt_ff           <= cnt_in;
      ch_ff            <= ch_in;
      ph_ff            <= ph_in;
      nb_ff            <= nb_in;
      h0_ff            <= h0_in;
      h1_ff            <= h1_in;
      res_ff           <= res_in;
      out_status_ff    <= out_status_in;
      out_pixel_ff     <= out_pixel_in;
      out_row_end_ff   <= out_row_end_in;
      out_frame_end_ff <= out_frame_end_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_out_pixel = out_pixel_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule
`default_nettype wire

[design/bilinear_rgba_scaler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_rgba_scaler
// Bilinear RGBA8888 scaler with a line ring store and pass-through copy.
//
//   channel   direction  handshake                fields
//   req       in         push / full              opcode, src_pixel
//   rsp       out        empty / pop              status, out_pixel, row_end, frame_end
//   csr       in         we (no wait)             index, data
//
// The front classifies one transaction per cycle, while the queue is not full,
// into a two-entry queue. In the back a push or refused transaction is answered
// from the start state; a copy reads its pixel in the read state; a blend starts,
// fetches the four neighbours through the single registered store read port,
// then takes three steps per channel on the shared blend unit.
// Reset is synchronous; the line store is not cleared.
// A full queue holds off req; a waiting result holds off the back only.
// ----------------------------------------------------------------------------
module bilinear_rgba_scaler
   import brs_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int LINES     = DEF_LINES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_opcode,
   input  wire logic [PIX_W-1:0]      req_src_pixel,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [1:0]                 rsp_status,
   output logic [PIX_W-1:0]           rsp_out_pixel,
   output logic                       rsp_row_end,
   output logic                       rsp_frame_end
);

   cmd_type  fe_cmd, q_cmd;
   logic     fe_push, q_full, q_empty, q_pop;

   brs_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .LINES     (LINES),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_push      (req_push),
      .req_opcode    (req_opcode),
      .req_src_pixel (req_src_pixel),
      .req_full      (req_full),
      .cmd_full      (q_full),
      .cmd_push      (fe_push),
      .cmd           (fe_cmd)
   );

   brs_fifo u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fe_push),
      .din   (fe_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_cmd),
      .empty (q_empty)
   );

   brs_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .LINES     (LINES),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (q_empty),
      .cmd           (q_cmd),
      .cmd_pop       (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_status    (rsp_status),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire
